>>> rtl/core/spk_pkg.sv
// Shared types and constants of the multichannel spike detector.
// Depends on nothing; every other file of the block imports it.
package spk_pkg;

    localparam int SPK_CHANNELS    = 8;
    localparam int SPK_SAMPLE_BITS = 16;

    localparam int CH_W     = 3;
    localparam int SMP_W    = 16;
    localparam int SINCE_W  = 16;
    localparam int RUN_W    = 8;
    localparam int CNT_W    = 32;
    localparam int SCAN_W   = 32;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_POLARITY  = 2'd1,
        REG_BLANKING  = 2'd2,
        REG_REQ_RUN   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SMP_W-1:0]   threshold;
        logic               positive;
        logic [SINCE_W-1:0] blanking;
        logic [RUN_W-1:0]   req_run;
    } t_cfg;

    // One channel's state word as held in the state memory.
    typedef struct packed {
        logic [SINCE_W-1:0] since;
        logic [RUN_W-1:0]   run;
        logic [CNT_W-1:0]   total;
        logic [SCAN_W-1:0]  last_scan;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{
        since:     {SINCE_W{1'b1}},
        run:       '0,
        total:     '0,
        last_scan: '0
    };

endpackage

>>> rtl/core/spk_if.sv
// Stream interfaces of the spike detector: sample input and result output.
// Depends on spk_pkg for the field widths.
interface spk_in_if;
    import spk_pkg::*;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel;
    logic [SMP_W-1:0]  sample;
    logic              new_scan;

    modport source (output valid, channel, sample, new_scan, input ready);
    modport sink   (input valid, channel, sample, new_scan, output ready);
endinterface

interface spk_out_if;
    import spk_pkg::*;
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   out_channel;
    logic              spike;
    logic [CNT_W-1:0]  spike_total;
    logic [SCAN_W-1:0] spike_scan;

    modport source (output valid, out_channel, spike, spike_total, spike_scan, input ready);
    modport sink   (input valid, out_channel, spike, spike_total, spike_scan, output ready);
endinterface

>>> rtl/core/multichannel_spike_detector.sv
// Top level of the multichannel spike detector: pipeline control around the
// state memory. Depends on spk_pkg, spk_if, spk_cfg, spk_mem and spk_update.
//
//   Channel      Kind            Direction  Payload
//   i_sample_ch  valid/ready     in         channel, sample, new_scan
//   o_result     valid/ready     out        out_channel, spike, spike_total, spike_scan
//   APB          psel/penable    in/out     four 32-bit registers at 4*i
//
// One sample per cycle is sustained while the output is not stalled; a result
// passes from the memory read into stage one, then through the update into the
// output register.
// The memory read-modify-write loop sets the rate; a write and a read of the
// same channel in one cycle are bridged by a forwarding register.
// Reset is synchronous; per-entry valid bits make the state readable at once.
// A stalled output holds the pipeline; one sample may still enter meanwhile.
module multichannel_spike_detector #(
    parameter int CHANNELS    = spk_pkg::SPK_CHANNELS,
    parameter int SAMPLE_BITS = spk_pkg::SPK_SAMPLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    spk_in_if.sink                      i_sample_ch,
    spk_out_if.source                   o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spk_pkg::APB_AW-1:0]  paddr,
    input  logic [spk_pkg::APB_DW-1:0]  pwdata,
    output logic [spk_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import spk_pkg::*;

    localparam int IDXW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_cfg              w_cfg;
    logic [SCAN_W-1:0] r_scan_cnt;
    logic [SCAN_W-1:0] w_scan_next;

    logic              r_s1_valid;
    logic [CH_W-1:0]   r_s1_channel;
    logic [SMP_W-1:0]  r_s1_sample;
    logic [SCAN_W-1:0] r_s1_scan;
    logic              r_fwd_hit;
    t_entry            r_fwd_entry;

    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_channel;
    logic              r_out_spike;
    logic [CNT_W-1:0]  r_out_total;
    logic [SCAN_W-1:0] r_out_scan;

    logic              w_in_acc;
    logic              w_s1_adv;
    logic              w_s1_in_range;
    logic              w_wr_en;
    t_entry            w_rd_entry;
    t_entry            w_cur;
    t_entry            w_next;
    logic              w_spike;

    spk_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_s1_adv      = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_sample_ch.ready = !r_s1_valid || w_s1_adv;
    assign w_in_acc      = i_sample_ch.valid && i_sample_ch.ready;
    assign w_s1_in_range = (int'(r_s1_channel) < CHANNELS);
    assign w_wr_en       = w_s1_adv && w_s1_in_range;
    assign w_scan_next   = r_scan_cnt + SCAN_W'(i_sample_ch.new_scan);

    spk_mem #(
        .CHANNELS (CHANNELS),
        .IDXW     (IDXW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_idx  (IDXW'(i_sample_ch.channel)),
        .i_wr_en   (w_wr_en),
        .i_wr_idx  (IDXW'(r_s1_channel)),
        .i_wr_data (w_next),
        .o_rd_data (w_rd_entry)
    );

    assign w_cur = r_fwd_hit ? r_fwd_entry : w_rd_entry;

    spk_update #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_update (
        .i_cur    (w_cur),
        .i_cfg    (w_cfg),
        .i_sample (r_s1_sample),
        .i_scan   (r_s1_scan),
        .o_next   (w_next),
        .o_spike  (w_spike)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_scan_cnt <= w_scan_next;
                // The memory read at this edge misses a write to the same channel.
                r_fwd_hit  <= w_wr_en && (r_s1_channel == i_sample_ch.channel);
            end
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_channel <= i_sample_ch.channel;
            r_s1_sample  <= i_sample_ch.sample;
            r_s1_scan    <= w_scan_next;
        end
        if (w_wr_en) begin
            r_fwd_entry <= w_next;
        end
        if (w_s1_adv) begin
            r_out_channel <= r_s1_channel;
            r_out_spike   <= w_s1_in_range && w_spike;
            r_out_total   <= w_s1_in_range ? w_next.total : '0;
            r_out_scan    <= w_s1_in_range ? w_next.last_scan : '0;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.out_channel = r_out_channel;
    assign o_result.spike       = r_out_spike;
    assign o_result.spike_total = r_out_total;
    assign o_result.spike_scan  = r_out_scan;

    a_wr_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> r_s1_valid && (!r_out_valid || o_result.ready))
        else $error("state write without an item leaving stage one");

    a_fwd_on_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_wr_en && (r_s1_channel == i_sample_ch.channel)) |=> r_fwd_hit)
        else $error("same-channel collision not forwarded");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_valid)
        else $error("accepted sample lost before stage one");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (int'(r_out_channel) >= CHANNELS))
            |-> (!r_out_spike && (r_out_total == '0) && (r_out_scan == '0)))
        else $error("result of an absent channel carries state");

endmodule

>>> rtl/core/spk_cfg.sv
// APB-style register bank holding the shared detection settings.
// Depends on spk_pkg for the register codes and the t_cfg struct.
module spk_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spk_pkg::APB_AW-1:0]  paddr,
    input  logic [spk_pkg::APB_DW-1:0]  pwdata,
    output logic [spk_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output spk_pkg::t_cfg               o_cfg
);
    import spk_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= 16'h8000;
            r_cfg.positive  <= 1'b1;
            r_cfg.blanking  <= '0;
            r_cfg.req_run   <= 8'd1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_THRESHOLD: r_cfg.threshold <= pwdata[SMP_W-1:0];
                REG_POLARITY:  r_cfg.positive  <= pwdata[0];
                REG_BLANKING:  r_cfg.blanking  <= pwdata[SINCE_W-1:0];
                REG_REQ_RUN:   r_cfg.req_run   <= pwdata[RUN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_THRESHOLD: prdata = APB_DW'(r_cfg.threshold);
            REG_POLARITY:  prdata = APB_DW'(r_cfg.positive);
            REG_BLANKING:  prdata = APB_DW'(r_cfg.blanking);
            REG_REQ_RUN:   prdata = APB_DW'(r_cfg.req_run);
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/core/spk_mem.sv
// Per-channel state memory: one write port, one registered read port.
// Entries never written since reset read back as ENTRY_RESET (spk_pkg).
module spk_mem #(
    parameter int CHANNELS = spk_pkg::SPK_CHANNELS,
    parameter int IDXW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDXW-1:0]  i_rd_idx,
    input  logic             i_wr_en,
    input  logic [IDXW-1:0]  i_wr_idx,
    input  spk_pkg::t_entry  i_wr_data,
    output spk_pkg::t_entry  o_rd_data
);
    import spk_pkg::*;

    t_entry                r_mem [CHANNELS];
    logic [CHANNELS-1:0]   r_valid;
    t_entry                r_rd_data;
    logic                  r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    // Valid bits stand in for a clearing pass; the read takes the old value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_idx];
            end
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : ENTRY_RESET;

endmodule

>>> rtl/core/spk_update.sv
// Next-state logic of one channel: blanking, threshold test, run and spike.
// Depends on spk_pkg for t_entry and t_cfg.
module spk_update #(
    parameter int SAMPLE_BITS = spk_pkg::SPK_SAMPLE_BITS
) (
    input  spk_pkg::t_entry              i_cur,
    input  spk_pkg::t_cfg                i_cfg,
    input  logic [spk_pkg::SMP_W-1:0]    i_sample,
    input  logic [spk_pkg::SCAN_W-1:0]   i_scan,
    output spk_pkg::t_entry              o_next,
    output logic                         o_spike
);
    import spk_pkg::*;

    logic [SMP_W-1:0]   w_smp;
    logic [SINCE_W-1:0] w_since;
    logic [RUN_W-1:0]   w_run;
    logic               w_level;
    logic               w_qual;

    assign w_smp   = SMP_W'(i_sample[SAMPLE_BITS-1:0]);
    assign w_since = (&i_cur.since) ? i_cur.since : i_cur.since + 1'b1;
    assign w_run   = (&i_cur.run) ? i_cur.run : i_cur.run + 1'b1;
    assign w_level = i_cfg.positive ? (w_smp > i_cfg.threshold) : (w_smp < i_cfg.threshold);
    assign w_qual  = (w_since >= i_cfg.blanking) && w_level;
    // A required run of zero is met by any qualifying sample, since w_run >= 1.
    assign o_spike = w_qual && (w_run >= i_cfg.req_run);

    always_comb begin
        o_next = i_cur;
        o_next.since = w_since;
        o_next.run   = w_qual ? w_run : '0;
        if (o_spike) begin
            o_next.since     = '0;
            o_next.run       = '0;
            o_next.total     = i_cur.total + 1'b1;
            o_next.last_scan = i_scan;
        end
    end

endmodule
